// ----- sv/gat_pkg.sv -----
package gat_pkg;

  typedef enum logic [1:0] {
    OP_TUPLE     = 2'd0,
    OP_MERGE     = 2'd1,
    OP_RESET_ALL = 2'd2,
    OP_NEXT      = 2'd3
  } gat_op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_TAG = 2'd1,
    STS_NO_MORE = 2'd2,
    STS_FULL    = 2'd3
  } gat_status_e;

  typedef enum logic [2:0] {
    AGG_SUM   = 3'd0,
    AGG_MIN   = 3'd1,
    AGG_MAX   = 3'd2,
    AGG_COUNT = 3'd3,
    AGG_AVG   = 3'd4,
    AGG_SMALL = 3'd5
  } gat_agg_e;

  typedef enum logic [2:0] {
    REG_AGG_OP   = 3'd0,
    REG_GROUPING = 3'd1,
    REG_SHIFT    = 3'd2,
    REG_NODE     = 3'd3,
    REG_TAG      = 3'd4
  } gat_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } gat_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_INIT_NEW,
    CELL_INIT_KEEP,
    CELL_WRITE
  } gat_cell_cmd_e;

  typedef struct packed {
    gat_cell_cmd_e cmd;
    logic [15:0]   new_key;
    logic [2:0]    agg_op;
    logic [15:0]   node;
  } gat_cell_ctrl_t;

  localparam logic [15:0] VAL_POS_MAX = 16'h7FFF;
  localparam logic [15:0] VAL_NEG_MAX = 16'h8000;
  localparam logic [15:0] ID_NONE     = 16'hFFFF;

endpackage

// ----- sv/gat_cell.sv -----
module gat_cell #(
  parameter int RS = 3,
  parameter int S  = 3
) (
  input  logic                   clk_i,
  input  gat_pkg::gat_cell_ctrl_t ctrl_i,
  input  logic [15:0]            left_key_i,
  input  logic                   left_empty_i,
  input  logic [RS-1:0][15:0]    left_vals_i,
  input  logic [RS-1:0][15:0]    left_ids_i,
  input  logic [15:0]            right_key_i,
  input  logic                   right_empty_i,
  input  logic [RS-1:0][15:0]    right_vals_i,
  input  logic [RS-1:0][15:0]    right_ids_i,
  input  logic [RS-1:0][15:0]    wr_vals_i,
  input  logic [RS-1:0][15:0]    wr_ids_i,
  output logic [15:0]            key_o,
  output logic                   empty_o,
  output logic [RS-1:0][15:0]    vals_o,
  output logic [RS-1:0][15:0]    ids_o
);

  logic [15:0]         key_q, key_d;
  logic                empty_q, empty_d;
  logic [RS-1:0][15:0] vals_q, vals_d, init_vals;
  logic [RS-1:0][15:0] ids_q, ids_d, init_ids;

  always_comb begin
    for (int k = 0; k < RS; k++) begin
      init_vals[k] = '0;
      init_ids[k]  = gat_pkg::ID_NONE;
    end
    unique case (ctrl_i.agg_op)
      gat_pkg::AGG_MIN: begin
        init_vals[0] = gat_pkg::VAL_POS_MAX;
        init_ids[0]  = ctrl_i.node;
      end
      gat_pkg::AGG_MAX: begin
        init_vals[0] = gat_pkg::VAL_NEG_MAX;
        init_ids[0]  = ctrl_i.node;
      end
      gat_pkg::AGG_SMALL: begin
        for (int k = 0; k < S; k++) init_vals[k] = gat_pkg::VAL_POS_MAX;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    key_d   = key_q;
    empty_d = empty_q;
    vals_d  = vals_q;
    ids_d   = ids_q;
    unique case (ctrl_i.cmd)
      gat_pkg::CELL_SHR: begin
        key_d = left_key_i; empty_d = left_empty_i;
        vals_d = left_vals_i; ids_d = left_ids_i;
      end
      gat_pkg::CELL_SHL: begin
        key_d = right_key_i; empty_d = right_empty_i;
        vals_d = right_vals_i; ids_d = right_ids_i;
      end
      gat_pkg::CELL_INIT_NEW: begin
        key_d = ctrl_i.new_key; empty_d = 1'b1;
        vals_d = init_vals; ids_d = init_ids;
      end
      gat_pkg::CELL_INIT_KEEP: begin
        empty_d = 1'b1; vals_d = init_vals; ids_d = init_ids;
      end
      gat_pkg::CELL_WRITE: begin
        empty_d = 1'b0; vals_d = wr_vals_i; ids_d = wr_ids_i;
      end
      default: begin
      end
    endcase
  end

  // Record contents are payload; they are always written before they are read.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    empty_q <= empty_d;
    vals_q  <= vals_d;
    ids_q   <= ids_d;
  end

  assign key_o   = key_q;
  assign empty_o = empty_q;
  assign vals_o  = vals_q;
  assign ids_o   = ids_q;

endmodule

// ----- sv/gat_alu.sv -----
module gat_alu #(
  parameter int RS = 3,
  parameter int S  = 3
) (
  input  logic [2:0]          agg_op_i,
  input  logic                is_merge_i,
  input  logic [15:0]         node_i,
  input  logic [15:0]         va_i,
  input  logic [15:0]         vb_i,
  input  logic [15:0]         vc_i,
  input  logic [15:0]         ida_i,
  input  logic [15:0]         idb_i,
  input  logic [15:0]         idc_i,
  input  logic [RS-1:0][15:0] vals_i,
  input  logic [RS-1:0][15:0] ids_i,
  output logic [RS-1:0][15:0] vals_o,
  output logic [RS-1:0][15:0] ids_o
);

  logic [S-1:0][15:0] mv, mi;

  always_comb begin
    for (int j = 0; j < S; j++) begin
      mv[j] = gat_pkg::VAL_POS_MAX;
      mi[j] = gat_pkg::ID_NONE;
    end
    mv[0] = va_i; mi[0] = ida_i;
    if (S > 1) begin
      mv[(S > 1) ? 1 : 0] = vb_i; mi[(S > 1) ? 1 : 0] = idb_i;
    end
    if (S > 2) begin
      mv[(S > 2) ? 2 : 0] = vc_i; mi[(S > 2) ? 2 : 0] = idc_i;
    end
  end

  always_comb begin
    logic [RS-1:0][15:0] nv, ni;
    logic                done;
    int                  j;
    nv   = vals_i;
    ni   = ids_i;
    done = 1'b0;
    j    = 0;
    unique case (agg_op_i)
      gat_pkg::AGG_SUM: nv[0] = nv[0] + va_i;
      gat_pkg::AGG_COUNT: nv[0] = nv[0] + (is_merge_i ? va_i : 16'd1);
      gat_pkg::AGG_AVG: begin
        nv[0] = nv[0] + va_i;
        nv[1] = nv[1] + (is_merge_i ? vb_i : 16'd1);
      end
      gat_pkg::AGG_MIN: begin
        if ($signed(nv[0]) > $signed(va_i)) begin
          nv[0] = va_i; ni[0] = is_merge_i ? ida_i : node_i;
        end
      end
      gat_pkg::AGG_MAX: begin
        if ($signed(nv[0]) < $signed(va_i)) begin
          nv[0] = va_i; ni[0] = is_merge_i ? ida_i : node_i;
        end
      end
      gat_pkg::AGG_SMALL: begin
        // Insertion into an ascending list; larger entries move up one slot.
        for (int i = 0; i < S; i++) begin
          if (!is_merge_i) begin
            if (!done && $signed(nv[i]) > $signed(va_i)) begin
              for (int k = S - 1; k > 0; k--) begin
                if (k > i) begin
                  nv[k] = nv[k-1]; ni[k] = ni[k-1];
                end
              end
              nv[i] = va_i; ni[i] = node_i;
              done  = 1'b1;
            end
          end else if (j < S) begin
            if ($signed(nv[i]) > $signed(mv[j[$clog2(S+1)-1:0]])) begin
              for (int k = S - 1; k > 0; k--) begin
                if (k > i) begin
                  nv[k] = nv[k-1]; ni[k] = ni[k-1];
                end
              end
              nv[i] = mv[j[$clog2(S+1)-1:0]];
              ni[i] = mi[j[$clog2(S+1)-1:0]];
              j     = j + 1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    vals_o = nv;
    ids_o  = ni;
  end

endmodule

// ----- sv/grouped_aggregate_table.sv -----
// Channel   Direction  Handshake                  Payload
// command   in         start / busy               operation_i .. scan_from_i
// result    out        done_o strobe, one cycle   status_o .. out_tag_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Reset all, next result and a rejected merge answer in the cycle after they are
// accepted. A tuple or merge with a present group goes through lookup, update and
// result, as does an insert; a full table with an empty record first removes it.
// The cell row compares all keys at once and shifts records one cell a cycle.
// Reset clears the record count and the control state; results cannot be stalled.
module grouped_aggregate_table #(
  parameter int MAX_GROUPS     = 32,
  parameter int SMALLEST_SLOTS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic signed [15:0] group_field_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  input  logic signed [15:0] value_c_i,
  input  logic [15:0] id_a_i,
  input  logic [15:0] id_b_i,
  input  logic [15:0] id_c_i,
  input  logic [7:0]  record_tag_i,
  input  logic [5:0]  scan_from_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic signed [15:0] group_no_o,
  output logic signed [15:0] out_a_o,
  output logic signed [15:0] out_b_o,
  output logic signed [15:0] out_c_o,
  output logic [15:0] out_id_a_o,
  output logic [15:0] out_id_b_o,
  output logic [15:0] out_id_c_o,
  output logic [4:0]  out_index_o,
  output logic [7:0]  out_tag_o
);

  localparam int RS = (SMALLEST_SLOTS > 2) ? SMALLEST_SLOTS : 2;
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // configuration
  logic [2:0]  agg_op_q;
  logic        grouping_q;
  logic [3:0]  shift_q;
  logic [15:0] node_q;
  logic [7:0]  tag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_op_q <= '0; grouping_q <= 1'b0; shift_q <= '0; node_q <= '0; tag_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gat_pkg::REG_AGG_OP:   agg_op_q   <= cfg_data_i[2:0];
        gat_pkg::REG_GROUPING: grouping_q <= cfg_data_i[0];
        gat_pkg::REG_SHIFT:    shift_q    <= cfg_data_i[3:0];
        gat_pkg::REG_NODE:     node_q     <= cfg_data_i;
        gat_pkg::REG_TAG:      tag_q      <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // cell row
  gat_pkg::gat_cell_ctrl_t ctrl [MAX_GROUPS];
  logic [15:0]         cell_key   [MAX_GROUPS];
  logic                cell_empty [MAX_GROUPS];
  logic [RS-1:0][15:0] cell_vals  [MAX_GROUPS];
  logic [RS-1:0][15:0] cell_ids   [MAX_GROUPS];
  logic [RS-1:0][15:0] alu_vals, alu_ids;

  for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
    localparam int L = (g > 0) ? g - 1 : g;
    localparam int R = (g < MAX_GROUPS - 1) ? g + 1 : g;
    gat_cell #(.RS(RS), .S(SMALLEST_SLOTS)) u_cell (
      .clk_i,
      .ctrl_i        (ctrl[g]),
      .left_key_i    (cell_key[L]),
      .left_empty_i  (cell_empty[L]),
      .left_vals_i   (cell_vals[L]),
      .left_ids_i    (cell_ids[L]),
      .right_key_i   (cell_key[R]),
      .right_empty_i (cell_empty[R]),
      .right_vals_i  (cell_vals[R]),
      .right_ids_i   (cell_ids[R]),
      .wr_vals_i     (alu_vals),
      .wr_ids_i      (alu_ids),
      .key_o         (cell_key[g]),
      .empty_o       (cell_empty[g]),
      .vals_o        (cell_vals[g]),
      .ids_o         (cell_ids[g])
    );
  end

  // control state and latched request
  gat_pkg::gat_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] r_q, r_d;
  logic          merge_q;
  logic [15:0]   key_q, va_q, vb_q, vc_q, ida_q, idb_q, idc_q;

  gat_alu #(.RS(RS), .S(SMALLEST_SLOTS)) u_alu (
    .agg_op_i   (agg_op_q),
    .is_merge_i (merge_q),
    .node_i     (node_q),
    .va_i       (va_q),
    .vb_i       (vb_q),
    .vc_i       (vc_q),
    .ida_i      (ida_q),
    .idb_i      (idb_q),
    .idc_i      (idc_q),
    .vals_i     (cell_vals[r_q]),
    .ids_i      (cell_ids[r_q]),
    .vals_o     (alu_vals),
    .ids_o      (alu_ids)
  );

  // parallel searches over the row
  logic          hit, emp_hit, scan_hit;
  logic [IW-1:0] hit_idx, ins_idx, emp_idx, scan_idx;

  always_comb begin
    hit = 1'b0; emp_hit = 1'b0; scan_hit = 1'b0;
    hit_idx = '0; emp_idx = '0; scan_idx = '0;
    ins_idx = IW'(count_q);
    for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
      if (i < int'(count_q)) begin
        if (cell_key[i] == key_q) begin
          hit = 1'b1; hit_idx = IW'(i);
        end
        if ($signed(cell_key[i]) > $signed(key_q)) ins_idx = IW'(i);
        if (!cell_empty[i] && i >= int'(scan_from_i)) begin
          scan_hit = 1'b1; scan_idx = IW'(i);
        end
      end
    end
    // The highest empty record is the one removed.
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (i < int'(count_q) && cell_empty[i]) begin
        emp_hit = 1'b1; emp_idx = IW'(i);
      end
    end
  end

  logic [15:0]         key_new;
  logic                emit;
  logic [1:0]          emit_status;
  logic [15:0]         emit_key;
  logic                emit_rec;
  logic [IW-1:0]       emit_idx;
  logic [RS-1:0][15:0] emit_vals, emit_ids;
  logic                accept;

  assign busy    = (state_q != gat_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign key_new = grouping_q ? 16'($signed(group_field_i) >>> shift_q) : 16'd0;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    r_d         = r_q;
    emit        = 1'b0;
    emit_status = gat_pkg::STS_OK;
    emit_key    = '0;
    emit_rec    = 1'b0;
    emit_idx    = '0;
    emit_vals   = alu_vals;
    emit_ids    = alu_ids;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      ctrl[i].cmd     = gat_pkg::CELL_HOLD;
      ctrl[i].new_key = key_q;
      ctrl[i].agg_op  = agg_op_q;
      ctrl[i].node    = node_q;
    end
    unique case (state_q)
      gat_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            gat_pkg::OP_TUPLE: state_d = gat_pkg::ST_LOOK;
            gat_pkg::OP_MERGE: begin
              if (record_tag_i == tag_q) begin
                state_d = gat_pkg::ST_LOOK;
              end else begin
                emit = 1'b1; emit_status = gat_pkg::STS_BAD_TAG;
                emit_key = group_field_i;
              end
            end
            gat_pkg::OP_RESET_ALL: begin
              emit = 1'b1;
              for (int i = 0; i < MAX_GROUPS; i++) ctrl[i].cmd = gat_pkg::CELL_INIT_KEEP;
            end
            default: begin
              emit = 1'b1;
              if (scan_hit) begin
                emit_key  = cell_key[scan_idx];
                emit_rec  = 1'b1;
                emit_idx  = scan_idx;
                emit_vals = cell_vals[scan_idx];
                emit_ids  = cell_ids[scan_idx];
              end else begin
                emit_status = gat_pkg::STS_NO_MORE;
              end
            end
          endcase
        end
      end
      gat_pkg::ST_LOOK: begin
        if (hit) begin
          r_d = hit_idx; state_d = gat_pkg::ST_UPD;
        end else if (count_q == CW'(MAX_GROUPS)) begin
          if (emp_hit) begin
            // Close the gap; the lookup runs again next cycle.
            for (int i = 0; i < MAX_GROUPS; i++) begin
              if (i >= int'(emp_idx) && i < int'(count_q) - 1) ctrl[i].cmd = gat_pkg::CELL_SHL;
            end
            count_d = count_q - CW'(1);
          end else begin
            emit = 1'b1; emit_status = gat_pkg::STS_FULL; emit_key = key_q;
            state_d = gat_pkg::ST_IDLE;
          end
        end else begin
          for (int i = 0; i < MAX_GROUPS; i++) begin
            if (i > int'(ins_idx) && i <= int'(count_q)) ctrl[i].cmd = gat_pkg::CELL_SHR;
            else if (i == int'(ins_idx)) ctrl[i].cmd = gat_pkg::CELL_INIT_NEW;
          end
          count_d = count_q + CW'(1);
          r_d     = ins_idx;
          state_d = gat_pkg::ST_UPD;
        end
      end
      gat_pkg::ST_UPD: begin
        for (int i = 0; i < MAX_GROUPS; i++) begin
          if (i == int'(r_q)) ctrl[i].cmd = gat_pkg::CELL_WRITE;
        end
        emit = 1'b1; emit_key = key_q; emit_rec = 1'b1; emit_idx = r_q;
        state_d = gat_pkg::ST_IDLE;
      end
      default: state_d = gat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gat_pkg::ST_IDLE;
      count_q <= '0;
      r_q     <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      r_q     <= r_d;
      done_o  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      merge_q <= (operation_i == gat_pkg::OP_MERGE);
      key_q   <= (operation_i == gat_pkg::OP_MERGE) ? group_field_i : key_new;
      va_q    <= value_a_i;
      vb_q    <= value_b_i;
      vc_q    <= value_c_i;
      ida_q   <= id_a_i;
      idb_q   <= id_b_i;
      idc_q   <= id_c_i;
    end
    if (emit) begin
      status_o   <= emit_status;
      group_no_o <= emit_key;
      if (emit_rec) begin
        out_a_o     <= emit_vals[0];
        out_b_o     <= emit_vals[1];
        out_c_o     <= (RS > 2) ? emit_vals[(RS > 2) ? 2 : 0] : 16'd0;
        out_id_a_o  <= emit_ids[0];
        out_id_b_o  <= emit_ids[1];
        out_id_c_o  <= (RS > 2) ? emit_ids[(RS > 2) ? 2 : 0] : gat_pkg::ID_NONE;
        out_index_o <= 5'(emit_idx);
        out_tag_o   <= tag_q;
      end else begin
        out_a_o <= '0; out_b_o <= '0; out_c_o <= '0;
        out_id_a_o <= '0; out_id_b_o <= '0; out_id_c_o <= '0;
        out_index_o <= '0; out_tag_o <= '0;
      end
    end
  end

  a_upd_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gat_pkg::ST_UPD |=> done_o && state_q == gat_pkg::ST_IDLE)
    else $error("update cycle did not produce a result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_GROUPS))
    else $error("record count beyond table size");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy || done_o)
    else $error("accepted request neither in work nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q != gat_pkg::ST_UPD)
    else $error("result strobe while an update is pending");

endmodule
